// ===== rtl/core/rvex_pkg.sv =====
// Package for the RV32IM integer execute unit.
// Holds operation codes, the kind enum and the item struct shared by the pipeline cells and the top level.
`timescale 1ns / 1ps
package rvex_pkg;
  localparam int unsigned STAGES = 34;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU  = 3'd3;
  localparam logic [2:0] F3_DIV    = 3'd4;
  localparam logic [2:0] F3_DIVU   = 3'd5;
  localparam logic [2:0] F3_REM    = 3'd6;
  localparam logic [2:0] F3_REMU   = 3'd7;

  localparam logic [6:0] F7_BASE = 7'b000_0000;
  localparam logic [6:0] F7_MD   = 7'b000_0001;
  localparam logic [6:0] F7_ALT  = 7'b010_0000;

  // Kind of work one item needs after decode.
  typedef enum logic [1:0] {
    KIND_DONE = 2'd0,
    KIND_MUL  = 2'd1,
    KIND_DIV  = 2'd2
  } kind_e;

  // What travels from cell to cell. For a divide, rem holds the partial
  // remainder, quo the dividend being shifted into quotient bits.
  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [2:0]  func;
    logic        illegal;
    logic [31:0] result;
    logic [32:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
    logic        neg_q;
    logic        neg_r;
    logic        special;
    logic [63:0] prod;
  } cell_t;
endpackage

// ===== rtl/core/rvex_cell.sv =====
// One cell of the execute chain: does one restoring divide step, forms the full
// multiply product, or only carries, and hands the item on. Uses rvex_pkg.
`timescale 1ns / 1ps
module rvex_cell
  import rvex_pkg::*;
#(
  parameter int unsigned MulStep = 0,
  parameter int unsigned DivStep = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  cell_t item_i,
  input  logic [31:0] ma_i,
  input  logic [31:0] mb_i,
  output cell_t item_o
);
  cell_t nxt;
  cell_t data_q;
  logic  valid_q;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    nxt = item_i;
    shifted = {item_i.rem[31:0], item_i.quo[31]};
    trial = shifted - {1'b0, item_i.dvs};
    if (DivStep == 1 && item_i.kind == KIND_DIV) begin
      if (!trial[32]) begin
        nxt.rem = trial;
      end else begin
        nxt.rem = shifted;
      end
      nxt.quo = {item_i.quo[30:0], ~trial[32]};
    end
    if (item_i.kind == KIND_MUL && MulStep == 1) begin
      nxt.prod = 64'(ma_i) * 64'(mb_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= nxt;
    end
  end

  always_comb begin
    item_o = data_q;
    item_o.valid = valid_q;
  end
endmodule

// ===== rtl/core/rv32im_integer_execute_unit.sv =====
// RV32IM integer execute unit: a chain of 34 cells, one item per cycle.
// Every operation passes through the head register and all cells from acceptance
// to result; the 32 divide steps, one per cell, set most of that depth. Throughput is one
// item per cycle; the whole chain advances unless the output is stalled.
// Reset clears all valid flags asynchronously; payloads are not reset.
`timescale 1ns / 1ps
module rv32im_integer_execute_unit
  import rvex_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [6:0]  variant_i,
  input  logic        use_imm_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic [11:0] imm_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_o,
  output logic        illegal_o
);
  cell_t d;
  cell_t head_q;
  logic  head_valid_q;
  cell_t chain [STAGES+1];
  logic  en;
  logic [31:0] a, b, simm, mag_a, mag_b, base;
  logic [4:0]  sh;
  logic        sa, sb;
  logic [31:0] q, r, res;

  assign en = !(chain[STAGES].valid && out_stall_i);
  assign in_stall_o = !en;

  assign a = operand_a_i;
  assign simm = {{20{imm_i[11]}}, imm_i};
  assign b = use_imm_i ? simm : operand_b_i;
  assign sh = use_imm_i ? imm_i[4:0] : operand_b_i[4:0];
  assign mag_a = a[31] ? (32'd0 - a) : a;
  assign mag_b = b[31] ? (32'd0 - b) : b;

  always_comb begin
    case (func_i)
      F3_ADD:  base = a + b;
      F3_SLL:  base = a << sh;
      F3_SLT:  base = {31'd0, $signed(a) < $signed(b)};
      F3_SLTU: base = {31'd0, a < b};
      F3_XOR:  base = a ^ b;
      F3_SR:   base = a >> sh;
      F3_OR:   base = a | b;
      default: base = a & b;
    endcase
  end

  always_comb begin
    d = '0;
    d.valid = in_valid_i;
    d.func = func_i;
    d.kind = KIND_DONE;
    d.result = base;
    sa = 1'b0;
    sb = 1'b0;
    if (use_imm_i) begin
      if (func_i == F3_SLL && imm_i[11:5] != F7_BASE) begin
        d.illegal = 1'b1;
      end else if (func_i == F3_SR) begin
        if (imm_i[11:5] == F7_ALT) begin
          d.result = 32'($signed(a) >>> sh);
        end else if (imm_i[11:5] != F7_BASE) begin
          d.illegal = 1'b1;
        end
      end
    end else if (variant_i == F7_ALT && func_i == F3_ADD) begin
      d.result = a - b;
    end else if (variant_i == F7_ALT && func_i == F3_SR) begin
      d.result = 32'($signed(a) >>> sh);
    end else if (variant_i == F7_MD) begin
      if (!func_i[2]) begin
        d.kind = KIND_MUL;
        sa = (func_i == F3_MULH || func_i == F3_MULHSU) && a[31];
        sb = (func_i == F3_MULH) && b[31];
        // MULH and MULHSU multiply magnitudes; sign is fixed at the end.
        d.quo = (func_i == F3_MULH || func_i == F3_MULHSU) ? mag_a : a;
        d.dvs = (func_i == F3_MULH) ? mag_b : b;
        d.neg_q = sa ^ sb;
      end else begin
        d.kind = KIND_DIV;
        if (func_i == F3_DIV || func_i == F3_REM) begin
          d.quo = mag_a;
          d.dvs = mag_b;
          d.neg_q = a[31] ^ b[31];
          d.neg_r = a[31];
        end else begin
          d.quo = a;
          d.dvs = b;
        end
        d.special = (b == 32'd0);
        d.result = a;
      end
    end else if (variant_i != F7_BASE) begin
      d.illegal = 1'b1;
    end
    if (d.illegal) begin
      d.result = '0;
      d.kind = KIND_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
    end else if (en) begin
      head_valid_q <= d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      head_q <= d;
    end
  end

  always_comb begin
    chain[0] = head_q;
    chain[0].valid = head_valid_q;
  end

  // Cells 0..31 carry divide steps; cell 32 forms the product.
  // Cell 33 only carries.
  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    rvex_cell #(
      .MulStep((i == 32) ? 1 : 0),
      .DivStep((i < 32) ? 1 : 0)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .item_i(chain[i]),
      .ma_i  (chain[i].quo),
      .mb_i  (chain[i].dvs),
      .item_o(chain[i+1])
    );
  end

  always_comb begin
    q = chain[STAGES].quo;
    r = chain[STAGES].rem[31:0];
    res = chain[STAGES].result;
    case (chain[STAGES].kind)
      KIND_MUL: begin
        if (chain[STAGES].func == F3_MUL) begin
          res = chain[STAGES].prod[31:0];
        end else if (chain[STAGES].neg_q) begin
          res = 32'((~chain[STAGES].prod + 64'd1) >> 32);
        end else begin
          res = chain[STAGES].prod[63:32];
        end
      end
      KIND_DIV: begin
        if (chain[STAGES].func[1]) begin
          if (!chain[STAGES].special) begin
            res = chain[STAGES].neg_r ? (32'd0 - r) : r;
          end
        end else if (chain[STAGES].special) begin
          res = '1;
        end else begin
          res = chain[STAGES].neg_q ? (32'd0 - q) : q;
        end
      end
      default: res = chain[STAGES].result;
    endcase
  end

  assign out_valid_o = chain[STAGES].valid;
  assign result_o = res;
  assign illegal_o = chain[STAGES].illegal;

`ifndef NO_ASSERTIONS
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_o))
    else $error("result changed under stall");
  a_illegal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && illegal_o |-> result_o == 32'd0)
    else $error("illegal item with nonzero result");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");
`endif
endmodule

// ===== dv/rv32im_integer_execute_unit_tb.sv =====
// Self-checking testbench for the RV32IM integer execute unit.
// Drives directed and random operations, predicts each result and compares in order.
// Depends on rvex_pkg and rv32im_integer_execute_unit.
`timescale 1ns / 1ps
module rv32im_integer_execute_unit_tb
  import rvex_pkg::*;
;

  localparam int unsigned LATENCY = 35;
  localparam int unsigned NUM_RANDOM = 1100;

  typedef struct packed {
    logic [31:0] result;
    logic        illegal;
  } exec_res_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [6:0]  variant;
    logic        use_imm;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [11:0] imm;
    logic        has_gold;
    logic [31:0] gold;
    logic        gold_ill;
  } op_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  func_i = '0;
  logic [6:0]  variant_i = '0;
  logic        use_imm_i = 1'b0;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic [11:0] imm_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] result_o;
  logic        illegal_o;

  exec_res_t pending_q[$];
  int unsigned mismatches = 0;
  bit stim_done = 1'b0;

  always #1 clk_i = ~clk_i;

  rv32im_integer_execute_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i, .variant_i, .use_imm_i,
    .operand_a_i, .operand_b_i, .imm_i, .out_valid_o, .out_stall_i, .result_o,
    .illegal_o
  );

  function automatic logic [31:0] arith_shift(logic [31:0] a, logic [4:0] sh);
    return $unsigned($signed(a) >>> sh);
  endfunction

  function automatic logic [31:0] base_alu(logic [2:0] f, logic [31:0] a, logic [31:0] b);
    case (f)
      F3_ADD:  return a + b;
      F3_SLL:  return a << b[4:0];
      F3_SLT:  return {31'd0, $signed(a) < $signed(b)};
      F3_SLTU: return {31'd0, a < b};
      F3_XOR:  return a ^ b;
      F3_SR:   return a >> b[4:0];
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  function automatic logic [31:0] muldiv_alu(logic [2:0] f, logic [31:0] a, logic [31:0] b);
    logic signed [63:0] ps;
    logic [63:0] pu;
    logic signed [64:0] psu;
    ps = $signed(a) * $signed(b);
    pu = {32'd0, a} * {32'd0, b};
    psu = $signed({{33{a[31]}}, a}) * $signed({33'd0, b});
    case (f)
      F3_MUL:    return pu[31:0];
      F3_MULH:   return ps[63:32];
      F3_MULHSU: return psu[63:32];
      F3_MULHU:  return pu[63:32];
      F3_DIV: begin
        if (b == 0) return 32'hFFFF_FFFF;
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return 32'h8000_0000;
        return $signed(a) / $signed(b);
      end
      F3_DIVU:   return (b == 0) ? 32'hFFFF_FFFF : a / b;
      F3_REM: begin
        if (b == 0) return a;
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return 32'd0;
        return $signed(a) % $signed(b);
      end
      default:   return (b == 0) ? a : a % b;
    endcase
  endfunction

  function automatic exec_res_t execute_op(op_row_t op);
    exec_res_t r;
    logic [31:0] simm;
    r = '0;
    simm = {{20{op.imm[11]}}, op.imm};
    if (op.use_imm) begin
      if (op.func == F3_SLL) begin
        if (op.imm[11:5] == F7_BASE) r.result = op.operand_a << op.imm[4:0];
        else r.illegal = 1'b1;
      end else if (op.func == F3_SR) begin
        if (op.imm[11:5] == F7_BASE) r.result = op.operand_a >> op.imm[4:0];
        else if (op.imm[11:5] == F7_ALT) r.result = arith_shift(op.operand_a, op.imm[4:0]);
        else r.illegal = 1'b1;
      end else begin
        r.result = base_alu(op.func, op.operand_a, simm);
      end
    end else if (op.variant == F7_BASE) begin
      r.result = base_alu(op.func, op.operand_a, op.operand_b);
    end else if (op.variant == F7_MD) begin
      r.result = muldiv_alu(op.func, op.operand_a, op.operand_b);
    end else if (op.variant == F7_ALT && op.func == F3_ADD) begin
      r.result = op.operand_a - op.operand_b;
    end else if (op.variant == F7_ALT && op.func == F3_SR) begin
      r.result = arith_shift(op.operand_a, op.operand_b[4:0]);
    end else begin
      r.illegal = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %h want %h", what, got, want);
    mismatches++;
  endtask

  // Boundary, small or fully random operands for random picks.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  function automatic op_row_t random_op();
    op_row_t op;
    op = '0;
    op.func = 3'($urandom_range(0, 7));
    op.use_imm = $urandom_range(0, 2) == 0;
    case ($urandom_range(0, 9))
      0, 1, 2: op.variant = F7_BASE;
      3, 4, 5: op.variant = F7_MD;
      6, 7:    op.variant = F7_ALT;
      default: op.variant = 7'($urandom_range(0, 127));
    endcase
    op.operand_a = pick_word();
    op.operand_b = pick_word();
    op.imm = 12'($urandom_range(0, 4095));
    if (op.use_imm && (op.func == F3_SLL || op.func == F3_SR) && $urandom_range(0, 3) != 0)
      op.imm[11:5] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
    return op;
  endfunction

  op_row_t directed[] = '{
    '{F3_ADD, F7_BASE, 1'b0, 32'hFFFF_FFFF, 32'd1, 12'd0, 1'b1, 32'd0, 1'b0},
    '{F3_ADD, F7_ALT, 1'b0, 32'd0, 32'd1, 12'd0, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{F3_SLL, F7_BASE, 1'b0, 32'd1, 32'hFFFF_FFFF, 12'd0, 1'b1, 32'h8000_0000, 1'b0},
    '{F3_SLT, F7_BASE, 1'b0, 32'h8000_0000, 32'd1, 12'd0, 1'b1, 32'd1, 1'b0},
    '{F3_SLTU, F7_BASE, 1'b0, 32'h8000_0000, 32'd1, 12'd0, 1'b1, 32'd0, 1'b0},
    '{F3_XOR, F7_BASE, 1'b0, 32'hFFFF_FFFF, 32'h0F0F_0F0F, 12'd0, 1'b0, 32'd0, 1'b0},
    '{F3_SR, F7_BASE, 1'b0, 32'h8000_0000, 32'd31, 12'd0, 1'b1, 32'd1, 1'b0},
    '{F3_SR, F7_ALT, 1'b0, 32'h8000_0000, 32'd63, 12'd0, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{F3_OR, F7_BASE, 1'b0, 32'h1234_5678, 32'h8765_4321, 12'd0, 1'b0, 32'd0, 1'b0},
    '{F3_AND, F7_BASE, 1'b0, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 12'd0, 1'b0, 32'd0, 1'b0},
    '{F3_MUL, F7_MD, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'd0, 1'b1, 32'd1, 1'b0},
    '{F3_MULH, F7_MD, 1'b0, 32'h8000_0000, 32'h8000_0000, 12'd0, 1'b1, 32'h4000_0000, 1'b0},
    '{F3_MULHSU, F7_MD, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'd0, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{F3_MULHU, F7_MD, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'd0, 1'b1, 32'hFFFF_FFFE, 1'b0},
    '{F3_DIV, F7_MD, 1'b0, 32'd7, 32'd0, 12'd0, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{F3_DIV, F7_MD, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 12'd0, 1'b1, 32'h8000_0000, 1'b0},
    '{F3_DIVU, F7_MD, 1'b0, 32'd7, 32'd0, 12'd0, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{F3_REM, F7_MD, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 12'd0, 1'b1, 32'd0, 1'b0},
    '{F3_REM, F7_MD, 1'b0, 32'hFFFF_FFF9, 32'd0, 12'd0, 1'b1, 32'hFFFF_FFF9, 1'b0},
    '{F3_REMU, F7_MD, 1'b0, 32'd9, 32'd0, 12'd0, 1'b1, 32'd9, 1'b0},
    '{F3_XOR, F7_ALT, 1'b0, 32'd1, 32'd1, 12'd0, 1'b1, 32'd0, 1'b1},
    '{F3_ADD, 7'h7F, 1'b0, 32'd1, 32'd1, 12'd0, 1'b1, 32'd0, 1'b1},
    '{F3_SLT, F7_BASE, 1'b1, 32'hFFFF_FFFE, 32'd0, 12'hFFF, 1'b1, 32'd1, 1'b0},
    '{F3_SLTU, F7_BASE, 1'b1, 32'd5, 32'd0, 12'hFFF, 1'b1, 32'd1, 1'b0},
    '{F3_SLL, F7_BASE, 1'b1, 32'd1, 32'd0, 12'h020, 1'b1, 32'd0, 1'b1},
    '{F3_SR, F7_BASE, 1'b1, 32'h8000_0000, 32'd0, 12'h41F, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{F3_SR, F7_BASE, 1'b1, 32'h8000_0000, 32'd0, 12'hFE1, 1'b1, 32'd0, 1'b1}
  };

  // Valid drops only when the sender actually idles, so back-to-back items
  // keep it high across the accepting edge.
  task automatic send_op(op_row_t op);
    exec_res_t want;
    int unsigned idle;
    idle = $urandom_range(0, 13);
    if (idle != 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    want = execute_op(op);
    if (op.has_gold && (want.result != op.gold || want.illegal != op.gold_ill))
      $display("note: table row disagrees with prediction for func %0d", op.func);
    in_valid_i  <= 1'b1;
    func_i      <= op.func;
    variant_i   <= op.variant;
    use_imm_i   <= op.use_imm;
    operand_a_i <= op.operand_a;
    operand_b_i <= op.operand_b;
    imm_i       <= op.imm;
    do @(posedge clk_i); while (in_stall_o);
    pending_q.push_back(op.has_gold ? exec_res_t'({op.gold, op.gold_ill}) : want);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[k]) send_op(directed[k]);
    in_valid_i <= 1'b0;
    // Let the pipeline drain completely once before the random stream.
    while (pending_q.size() != 0) @(posedge clk_i);
    for (int n = 0; n < NUM_RANDOM; n++) send_op(random_op());
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
    stim_done = 1'b1;
  end

  // Receiver stall: a random count of stalled cycles per item, sometimes none.
  initial begin
    int unsigned hold;
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      repeat (hold) begin
        out_stall_i <= 1'b1;
        @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && rst_ni));
    end
  end

  always @(posedge clk_i) begin
    exec_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", result_o, 32'd0);
      end else begin
        want = pending_q.pop_front();
        if (result_o !== want.result) report_mismatch("result", result_o, want.result);
        if (illegal_o !== want.illegal)
          report_mismatch("illegal", {31'd0, illegal_o}, {31'd0, want.illegal});
      end
    end
  end

  initial begin
    wait (stim_done);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("rv32im_integer_execute_unit_tb: done, clean");
    end else begin
      $display("rv32im_integer_execute_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("rv32im_integer_execute_unit_tb: done, errors");
    $finish;
  end
endmodule
